FILE: hdl/qrs_pkg.sv
package qrs_pkg;

   // Coefficient and fraction widths of the solver.
   localparam int CW        = 16;
   localparam int FRAC_BITS = 16;

   // Derived datapath widths.
   localparam int PW       = 2 * CW;              // coefficient products
   localparam int DS_W     = PW + 2;              // signed discriminant
   localparam int D_W      = PW + 1;              // nonnegative discriminant
   localparam int DP       = (D_W + 1) / 2;       // bit pairs in the discriminant
   localparam int SQ_N     = DP + FRAC_BITS;      // square root steps
   localparam int ROOT_W   = SQ_N;                // square root width
   localparam int REM_W    = ROOT_W + 2;          // square root remainder
   localparam int NB_W     = CW + FRAC_BITS + 1;  // scaled -b
   localparam int NUM_W    = ROOT_W + 2;          // signed numerator
   localparam int QW       = NUM_W - 1;           // numerator and quotient magnitude
   localparam int DEN_W    = CW + 1;              // magnitude of 2a
   localparam int ROOT_OUT = CW + FRAC_BITS + 2;  // result root width

   localparam int QUEUE_DEPTH = 4;
   localparam int QA_W        = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      ST_TWO      = 2'd0,
      ST_DOUBLE   = 2'd1,
      ST_NONE     = 2'd2,
      ST_NOT_QUAD = 2'd3
   } status_type;

   // Entry handed from the front end to the back end.
   typedef struct packed {
      logic signed [CW-1:0] a;
      logic signed [CW-1:0] b;
      logic [PW-1:0]        bb;
      logic signed [PW-1:0] ac;
   } fe_type;

   // One stage of the square root pipeline.
   typedef struct packed {
      logic                   valid;
      status_type             status;
      logic [D_W-1:0]         d;
      logic signed [NB_W-1:0] nb;
      logic [DEN_W-1:0]       den;
      logic                   a_neg;
      logic [REM_W-1:0]       rem;
      logic [ROOT_W-1:0]      root;
   } sq_type;

   // One stage of the two-lane divider pipeline.
   typedef struct packed {
      logic             valid;
      status_type       status;
      logic             a_neg;
      logic [DEN_W-1:0] den;
      logic [QW-1:0]    nm1;
      logic [QW-1:0]    nm2;
      logic [DEN_W-1:0] r1;
      logic [DEN_W-1:0] r2;
      logic [QW-1:0]    q1;
      logic [QW-1:0]    q2;
      logic             neg1;
      logic             neg2;
   } dv_type;

endpackage

FILE: hdl/qrs_req_if.sv
interface qrs_req_if;
   import qrs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic signed [CW-1:0] coef_a;
   logic signed [CW-1:0] coef_b;
   logic signed [CW-1:0] coef_c;

   modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
   modport sink (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

FILE: hdl/qrs_rsp_if.sv
interface qrs_rsp_if;
   import qrs_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [1:0]                 status;
   logic signed [ROOT_OUT-1:0] root_low;
   logic signed [ROOT_OUT-1:0] root_high;

   modport source (output valid, output status, output root_low, output root_high, input ready);
   modport sink (input valid, input status, input root_low, input root_high, output ready);
endinterface

FILE: hdl/qrs_front.sv
module qrs_front (
   qrs_req_if.sink          req_chan,
   input  logic             queue_full,
   output logic             push_valid,
   output qrs_pkg::fe_type  push_data
);
   import qrs_pkg::*;

   logic signed [2*CW-1:0] bb_full;

   // The two coefficient products are formed here, so the back end only subtracts.
   always_comb begin
      bb_full         = req_chan.coef_b * req_chan.coef_b;
      push_data.a     = req_chan.coef_a;
      push_data.b     = req_chan.coef_b;
      push_data.bb    = PW'(unsigned'(bb_full));
      push_data.ac    = req_chan.coef_a * req_chan.coef_c;
      push_valid      = req_chan.valid && !queue_full;
      req_chan.ready  = !queue_full;
   end
endmodule

FILE: hdl/qrs_queue.sv
module qrs_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  qrs_pkg::fe_type push_data,
   input  logic            pop,
   output logic            full,
   output logic            not_empty,
   output qrs_pkg::fe_type head
);
   import qrs_pkg::*;

   fe_type           mem_ff [QUEUE_DEPTH];
   logic [QA_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QA_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QA_W:0]    count_ff, count_in;
   logic             do_pop;

   always_comb begin
      full      = (count_ff == (QA_W + 1)'(QUEUE_DEPTH));
      not_empty = (count_ff != '0);
      head      = mem_ff[rd_ptr_ff];
      do_pop    = pop && not_empty;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QA_W + 1)'(push) - (QA_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule

FILE: hdl/qrs_back.sv
module qrs_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  qrs_pkg::fe_type head,
   output logic            pop,
   qrs_rsp_if.source       rsp_chan
);
   import qrs_pkg::*;

   sq_type sq_ff [SQ_N+1];
   sq_type sq_in [SQ_N+1];
   dv_type dv_ff [QW+1];
   dv_type dv_in [QW+1];

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 rsp_status_ff, rsp_status_in;
   logic signed [ROOT_OUT-1:0] rsp_low_ff, rsp_low_in;
   logic signed [ROOT_OUT-1:0] rsp_high_ff, rsp_high_in;
   logic                       adv;

   // The whole pipeline moves together whenever the result register can take a value.
   assign adv = !rsp_valid_ff || rsp_chan.ready;
   assign pop = adv;

   // Classification stage: discriminant, scaled -b and the magnitude of 2a.
   logic signed [DS_W-1:0] d_s;
   logic signed [NB_W-1:0] b_ext;
   logic [CW:0]            a_ext;
   logic [CW:0]            a_mag;

   always_comb begin
      d_s   = signed'({2'b00, head.bb}) - ({{2{head.ac[PW-1]}}, head.ac} <<< 2);
      b_ext = {{(NB_W-CW){head.b[CW-1]}}, head.b};
      a_ext = {head.a[CW-1], head.a};
      a_mag = head.a[CW-1] ? (~a_ext + 1'b1) : a_ext;
      sq_in[0].valid = head_valid;
      if (head.a == '0) begin
         sq_in[0].status = ST_NOT_QUAD;
      end else if (d_s[DS_W-1]) begin
         sq_in[0].status = ST_NONE;
      end else if (d_s == '0) begin
         sq_in[0].status = ST_DOUBLE;
      end else begin
         sq_in[0].status = ST_TWO;
      end
      sq_in[0].d     = d_s[D_W-1:0];
      sq_in[0].nb    = -(b_ext <<< FRAC_BITS);
      sq_in[0].den   = {a_mag[CW-1:0], 1'b0};
      sq_in[0].a_neg = head.a[CW-1];
      sq_in[0].rem   = '0;
      sq_in[0].root  = '0;
   end

   // Square root: one root bit per stage, fraction steps bring in zero pairs.
   for (genvar k = 0; k < SQ_N; k++) begin : g_sq
      logic [1:0]        pair;
      logic [REM_W+1:0]  rem_sh;
      logic [REM_W+1:0]  trial;
      logic              take;
      logic [2*DP-1:0]   dx;

      assign dx = {{(2*DP-D_W){1'b0}}, sq_ff[k].d};
      if (k < DP) begin : g_pair
         assign pair = dx[2*(DP-1-k) +: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end

      always_comb begin
         rem_sh = {sq_ff[k].rem, pair};
         trial  = (REM_W + 2)'({sq_ff[k].root, 2'b01});
         take   = (rem_sh >= trial);
         sq_in[k+1]       = sq_ff[k];
         sq_in[k+1].rem   = take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
         sq_in[k+1].root  = {sq_ff[k].root[ROOT_W-2:0], take};
      end
   end

   for (genvar k = 0; k <= SQ_N; k++) begin : g_sq_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_ff[k].valid <= 1'b0;
         end else if (adv) begin
            sq_ff[k] <= sq_in[k];
         end
      end
   end

   // Numerators -b*2^F + S and -b*2^F - S, split into sign and magnitude.
   logic signed [NUM_W-1:0] nb_w, s_w, n1, n2, n1_mag, n2_mag;

   always_comb begin
      nb_w   = {{(NUM_W-NB_W){sq_ff[SQ_N].nb[NB_W-1]}}, sq_ff[SQ_N].nb};
      s_w    = signed'({{(NUM_W-ROOT_W){1'b0}}, sq_ff[SQ_N].root});
      n1     = nb_w + s_w;
      n2     = nb_w - s_w;
      n1_mag = n1[NUM_W-1] ? -n1 : n1;
      n2_mag = n2[NUM_W-1] ? -n2 : n2;
      dv_in[0].valid  = sq_ff[SQ_N].valid;
      dv_in[0].status = sq_ff[SQ_N].status;
      dv_in[0].a_neg  = sq_ff[SQ_N].a_neg;
      dv_in[0].den    = sq_ff[SQ_N].den;
      dv_in[0].nm1    = n1_mag[QW-1:0];
      dv_in[0].nm2    = n2_mag[QW-1:0];
      dv_in[0].r1     = '0;
      dv_in[0].r2     = '0;
      dv_in[0].q1     = '0;
      dv_in[0].q2     = '0;
      dv_in[0].neg1   = n1[NUM_W-1] ^ sq_ff[SQ_N].a_neg;
      dv_in[0].neg2   = n2[NUM_W-1] ^ sq_ff[SQ_N].a_neg;
   end

   // Restoring division, one quotient bit per stage in each lane.
   for (genvar j = 0; j < QW; j++) begin : g_dv
      logic [DEN_W:0] sh1, sh2, den_x;
      logic           ge1, ge2;

      always_comb begin
         den_x = {1'b0, dv_ff[j].den};
         sh1   = {dv_ff[j].r1, dv_ff[j].nm1[QW-1]};
         sh2   = {dv_ff[j].r2, dv_ff[j].nm2[QW-1]};
         ge1   = (sh1 >= den_x);
         ge2   = (sh2 >= den_x);
         dv_in[j+1]     = dv_ff[j];
         dv_in[j+1].r1  = ge1 ? DEN_W'(sh1 - den_x) : DEN_W'(sh1);
         dv_in[j+1].r2  = ge2 ? DEN_W'(sh2 - den_x) : DEN_W'(sh2);
         dv_in[j+1].q1  = {dv_ff[j].q1[QW-2:0], ge1};
         dv_in[j+1].q2  = {dv_ff[j].q2[QW-2:0], ge2};
         dv_in[j+1].nm1 = {dv_ff[j].nm1[QW-2:0], 1'b0};
         dv_in[j+1].nm2 = {dv_ff[j].nm2[QW-2:0], 1'b0};
      end
   end

   for (genvar j = 0; j <= QW; j++) begin : g_dv_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j].valid <= 1'b0;
         end else if (adv) begin
            dv_ff[j] <= dv_in[j];
         end
      end
   end

   // Signs are applied here. With 2a positive the plus-root quotient is the larger one,
   // and with 2a negative it is the smaller one.
   logic signed [NUM_W-1:0] q1_s, q2_s, lo_s, hi_s;

   always_comb begin
      q1_s = signed'({1'b0, dv_ff[QW].q1});
      q2_s = signed'({1'b0, dv_ff[QW].q2});
      if (dv_ff[QW].neg1) begin
         q1_s = -q1_s;
      end
      if (dv_ff[QW].neg2) begin
         q2_s = -q2_s;
      end
      if (dv_ff[QW].a_neg) begin
         lo_s = q1_s;
         hi_s = q2_s;
      end else begin
         lo_s = q2_s;
         hi_s = q1_s;
      end
      rsp_valid_in  = dv_ff[QW].valid;
      rsp_status_in = dv_ff[QW].status;
      case (dv_ff[QW].status)
         ST_TWO, ST_DOUBLE: begin
            rsp_low_in  = lo_s[ROOT_OUT-1:0];
            rsp_high_in = hi_s[ROOT_OUT-1:0];
         end
         default: begin
            rsp_low_in  = '0;
            rsp_high_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff  <= rsp_valid_in;
         rsp_status_ff <= rsp_status_in;
         rsp_low_ff    <= rsp_low_in;
         rsp_high_ff   <= rsp_high_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.root_low  = rsp_low_ff;
   assign rsp_chan.root_high = rsp_high_ff;
endmodule

FILE: hdl/quadratic_root_solver_top.sv
// An accepted transaction is written into the queue, then passes through the 33-step square root and the
// 34-step divider pipelines and the result register. Throughput: one transaction per cycle while
// the receiver is ready; a four-entry queue decouples intake from the pipeline.
// Reset is synchronous and active high; it empties the queue and clears all valid bits.
module quadratic_root_solver_top (
   input  logic      clock,
   input  logic      reset,
   qrs_req_if.sink   req_chan,
   qrs_rsp_if.source rsp_chan
);
   import qrs_pkg::*;

   logic   queue_full;
   logic   push_valid;
   fe_type push_data;
   logic   pop;
   logic   head_valid;
   fe_type head;

   qrs_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   qrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (head_valid),
      .head      (head)
   );

   qrs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );
endmodule

FILE: sim/tb_quadratic_root_solver_top.sv
`timescale 1ns / 1ps

module tb_quadratic_root_solver_top;
   import qrs_pkg::*;

   typedef struct {
      status_type              status;
      logic signed [ROOT_OUT-1:0] lo;
      logic signed [ROOT_OUT-1:0] hi;
   } roots_type;

   // Keeps the roots predicted for each accepted equation and checks results in order.
   class root_scoreboard;
      roots_type pending[$];
      int        errors = 0;

      function automatic logic [63:0] scaled_sqrt(logic [63:0] d);
         logic [63:0] rem;
         logic [63:0] root;
         logic [63:0] trial;
         rem  = 0;
         root = 0;
         for (int i = 31 + FRAC_BITS; i >= 0; i--) begin
            rem   = (rem << 2) | ((i >= FRAC_BITS) ? ((d >> (2 * (i - FRAC_BITS))) & 3) : 0);
            trial = (root << 2) | 1;
            if (rem >= trial) begin
               rem  = rem - trial;
               root = (root << 1) | 1;
            end else begin
               root = root << 1;
            end
         end
         return root;
      endfunction

      function void note_equation(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                                  logic signed [CW-1:0] c);
         roots_type   r;
         longint      la;
         longint      lb;
         longint      disc;
         longint      nb;
         longint      den;
         longint      s;
         longint      r1;
         longint      r2;
         la = a;
         lb = b;
         r.lo = '0;
         r.hi = '0;
         if (la == 0) begin
            r.status = ST_NOT_QUAD;
         end else begin
            disc = lb * lb - 4 * la * longint'(c);
            if (disc < 0) begin
               r.status = ST_NONE;
            end else begin
               nb  = -lb * (longint'(1) << FRAC_BITS);
               den = 2 * la;
               s   = longint'(scaled_sqrt(disc));
               if (disc == 0) begin
                  r.status = ST_DOUBLE;
                  r.lo = ROOT_OUT'(nb / den);
                  r.hi = r.lo;
               end else begin
                  r1 = (nb + s) / den;
                  r2 = (nb - s) / den;
                  r.status = ST_TWO;
                  r.lo = ROOT_OUT'((r1 > r2) ? r2 : r1);
                  r.hi = ROOT_OUT'((r1 > r2) ? r1 : r2);
               end
            end
         end
         pending.push_back(r);
      endfunction

      function void check_roots(logic [1:0] status, logic [ROOT_OUT-1:0] lo,
                                logic [ROOT_OUT-1:0] hi);
         roots_type e;
         if (pending.size() == 0) begin
            $error("unexpected result transaction: status %0d", status);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, status);
            errors++;
         end
         if (lo !== e.lo) begin
            $error("root_low: expected %0d, actual %0d", e.lo, $signed(lo));
            errors++;
         end
         if (hi !== e.hi) begin
            $error("root_high: expected %0d, actual %0d", e.hi, $signed(hi));
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   quiet_cycles = 0;
   root_scoreboard board = new();

   qrs_req_if req_chan ();
   qrs_rsp_if rsp_chan ();

   quadratic_root_solver_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   always #5 clock = ~clock;

   // The receiver stalls at random and checks each accepted result transaction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_roots(rsp_chan.status, rsp_chan.root_low, rsp_chan.root_high);
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 5000) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic send_equation(logic signed [CW-1:0] a, logic signed [CW-1:0] b,
                                logic signed [CW-1:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 0;
         @(posedge clock);
      end
      req_chan.valid  <= 1;
      req_chan.coef_a <= a;
      req_chan.coef_b <= b;
      req_chan.coef_c <= c;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      board.note_equation(a, b, c);
   endtask

   task automatic send_random_equation();
      logic signed [CW-1:0] a;
      logic signed [CW-1:0] b;
      logic signed [CW-1:0] c;
      int                   r;
      int                   k;
      r = $urandom_range(9);
      a = CW'($urandom);
      b = CW'($urandom);
      c = CW'($urandom);
      if (r < 2) begin
         a = CW'(int'($urandom_range(15)) - 8);
      end else if (r == 2) begin
         a = '0;
      end else if (r == 3) begin
         // Perfect square: (k*x + m)^2 gives a zero discriminant.
         k = $urandom_range(181) - 90;
         if (k == 0) k = 1;
         a = CW'(k * k);
         b = CW'(2 * k * ($signed($urandom_range(180)) - 90));
         c = CW'((b / (2 * k)) * (b / (2 * k)));
      end else if (r == 4) begin
         a = CW'(int'($urandom_range(255)) - 128);
         b = CW'(int'($urandom_range(255)) - 128);
         c = CW'(int'($urandom_range(255)) - 128);
      end
      send_equation(a, b, c);
   endtask

   initial begin
      req_chan.valid  = 0;
      req_chan.coef_a = 0;
      req_chan.coef_b = 0;
      req_chan.coef_c = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_equation(16'sd1, -16'sd3, 16'sd2);
      send_equation(-16'sd1, 16'sd3, -16'sd2);
      send_equation(16'sd1, 16'sd2, 16'sd1);
      send_equation(16'sd1, 16'sd0, 16'sd1);
      send_equation(16'sd0, 16'sd5, 16'sd7);
      send_equation(16'sd0, 16'sd0, 16'sd0);
      send_equation(16'sd1, 16'sd0, 16'sd0);
      send_equation(16'sd1, -16'sd32768, -16'sd32768);
      send_equation(16'sd1, 16'sd32767, 16'sd32767);
      send_equation(-16'sd32768, -16'sd32768, 16'sd32767);
      send_equation(16'sd32767, 16'sd32767, -16'sd32768);
      send_equation(-16'sd32768, -16'sd32768, -16'sd32768);
      send_equation(16'sd32767, 16'sd32767, 16'sd32767);
      send_equation(-16'sd1, 16'sd0, 16'sd32767);
      send_equation(16'sd1, 16'sd0, -16'sd32768);
      send_equation(16'sd3, 16'sd1, -16'sd1);
      send_equation(-16'sd3, 16'sd1, 16'sd1);
      send_equation(16'sd4, -16'sd4, 16'sd1);
      send_equation(-16'sd1, 16'sd1, 16'sd0);

      send_idle_pct = 28;
      recv_idle_pct = 59;
      repeat (240) send_random_equation();
      send_idle_pct = 59;
      recv_idle_pct = 28;
      repeat (240) send_random_equation();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (220) send_random_equation();
      req_chan.valid <= 0;

      while (board.pending.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
